FILE: sv/command_frame_receiver_core_assert.svh
// Assertion macros for the command frame receiver.
// Used by command_frame_receiver_core.sv; expects aclk and aresetn in scope.
`ifndef COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge out of reset.
`define CFRC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define CFRC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);
`else
`define CFRC_ASSERT_ALWAYS(lbl, cond, msg)
`define CFRC_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

FILE: sv/cfrc_pkg.sv
// Shared types, constants and functions of the command frame receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cfrc_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int COUNT_W          = 7;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_START  = 3'd1;
    localparam logic [2:0] STATUS_INCOMPLETE = 3'd2;
    localparam logic [2:0] STATUS_BAD_CRC    = 3'd3;
    localparam logic [2:0] STATUS_BAD_CMD    = 3'd4;
    localparam logic [2:0] STATUS_BAD_END    = 3'd5;

    localparam logic [7:0] CMD_NO_INFO  = 8'd1;
    localparam logic [7:0] CMD_TWO_INFO = 8'd2;
    localparam logic [7:0] CMD_ONE_LO   = 8'd3;
    localparam logic [7:0] CMD_ONE_HI   = 8'd6;

    localparam int RESULT_W = 51;
    localparam int TDATA_W  = 56;

    // Lowest bits hold status.
    typedef struct packed {
        logic [15:0] frame_crc;
        logic [7:0]  info_second;
        logic [7:0]  info_first;
        logic [7:0]  info_length;
        logic [7:0]  command_code;
        logic [2:0]  status;
    } result_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] start_mark(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0: m = 8'hFF;
            2'd1: m = 8'hAA;
            2'd2: m = 8'hAA;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] end_mark(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0: m = 8'hEE;
            2'd1: m = 8'h55;
            2'd2: m = 8'h55;
            default: m = 8'hEE;
        endcase
        return m;
    endfunction

    function automatic logic cmd_length_ok(input logic [7:0] cmd, input logic [7:0] len);
        logic ok;
        if (cmd == CMD_NO_INFO) begin
            ok = (len == 8'd0);
        end else if (cmd == CMD_TWO_INFO) begin
            ok = (len == 8'd2);
        end else if (cmd >= CMD_ONE_LO && cmd <= CMD_ONE_HI) begin
            ok = (len == 8'd1);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cfrc_frame_check.sv
// Burst state and frame judgement: parses one word per step, runs the CRC,
// judges the frame at idle or when the buffer depth fills. Uses cfrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfrc_frame_check #(
    parameter int BUFFER_DEPTH = cfrc_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_en,
    input  wire logic                         in_action,
    input  wire logic [7:0]                   in_byte,
    input  wire logic [15:0]                  crc_init,
    output logic                              res_valid,
    output cfrc_pkg::result_t                 res_data,
    output logic [cfrc_pkg::COUNT_W-1:0]      burst_cnt
);

    localparam int CW = cfrc_pkg::COUNT_W;

    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [15:0]   crc_reg,   crc_next;
    logic [7:0]    cmd_reg,   cmd_next;
    logic [7:0]    len_reg,   len_next;
    logic [7:0]    info0_reg, info0_next;
    logic [7:0]    info1_reg, info1_next;
    logic [15:0]   rcrc_reg,  rcrc_next;
    logic          serr_reg,  serr_next;
    logic          eerr_reg,  eerr_next;

    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic [8:0]  pos;
    logic [8:0]  k_off;
    logic [8:0]  t_off;
    logic        in_info;
    logic [7:0]  cnt_inc;

    // Values the judgement looks at.
    logic [7:0]  e_cnt;
    logic [15:0] e_crc;
    logic [7:0]  e_cmd;
    logic [7:0]  e_len;
    logic [15:0] e_rcrc;
    logic        e_serr;
    logic        e_eerr;
    logic [2:0]  status;

    always_comb begin
        pos      = {2'b00, cnt_reg};
        crc_base = (cnt_reg == '0) ? crc_init : crc_reg;
        crc_upd  = cfrc_pkg::crc_update(crc_base, in_byte);
        k_off    = pos - 9'd6;
        in_info  = (pos >= 9'd6) && (k_off < {1'b0, len_reg});
        t_off    = k_off - {1'b0, len_reg};
        cnt_inc  = {1'b0, cnt_reg} + 8'd1;

        cnt_next   = cnt_inc[CW-1:0];
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        info0_next = info0_reg;
        info1_next = info1_reg;
        rcrc_next  = rcrc_reg;
        serr_next  = serr_reg;
        eerr_next  = eerr_reg;

        if (pos < 9'd4) begin
            if (in_byte != cfrc_pkg::start_mark(cnt_reg[1:0])) begin
                serr_next = 1'b1;
            end
            crc_next = crc_upd;
        end else if (pos == 9'd4) begin
            cmd_next = in_byte;
            crc_next = crc_upd;
        end else if (pos == 9'd5) begin
            len_next = in_byte;
            crc_next = crc_upd;
        end else if (in_info) begin
            crc_next = crc_upd;
            if (k_off == 9'd0) begin
                info0_next = in_byte;
            end
            if (k_off == 9'd1) begin
                info1_next = in_byte;
            end
        end else if (t_off == 9'd0) begin
            rcrc_next = {rcrc_reg[15:8], in_byte};
        end else if (t_off == 9'd1) begin
            rcrc_next = {in_byte, rcrc_reg[7:0]};
        end else if (t_off < 9'd6) begin
            // End mark; anything after it is ignored.
            if (in_byte != cfrc_pkg::end_mark(t_off[1:0] - 2'd2)) begin
                eerr_next = 1'b1;
            end
        end

        if (in_action) begin
            e_cnt  = {1'b0, cnt_reg};
            e_crc  = crc_reg;
            e_cmd  = cmd_reg;
            e_len  = len_reg;
            e_rcrc = rcrc_reg;
            e_serr = serr_reg;
            e_eerr = eerr_reg;
            res_data.info_first  = info0_reg;
            res_data.info_second = info1_reg;
            res_valid = (cnt_reg != '0);
        end else begin
            e_cnt  = cnt_inc;
            e_crc  = crc_next;
            e_cmd  = cmd_next;
            e_len  = len_next;
            e_rcrc = rcrc_next;
            e_serr = serr_next;
            e_eerr = eerr_next;
            res_data.info_first  = info0_next;
            res_data.info_second = info1_next;
            res_valid = (cnt_inc >= 8'(BUFFER_DEPTH));
        end

        if (e_serr) begin
            status = cfrc_pkg::STATUS_BAD_START;
        end else if (e_cnt < 8'd6 || {1'b0, e_cnt} < 9'd12 + {1'b0, e_len}) begin
            status = cfrc_pkg::STATUS_INCOMPLETE;
        end else if (e_rcrc != e_crc) begin
            status = cfrc_pkg::STATUS_BAD_CRC;
        end else if (!cfrc_pkg::cmd_length_ok(e_cmd, e_len)) begin
            status = cfrc_pkg::STATUS_BAD_CMD;
        end else if (e_eerr) begin
            status = cfrc_pkg::STATUS_BAD_END;
        end else begin
            status = cfrc_pkg::STATUS_OK;
        end

        res_data.status       = status;
        res_data.command_code = e_cmd;
        res_data.info_length  = e_len;
        res_data.frame_crc    = e_crc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            crc_reg   <= cfrc_pkg::CRC_INIT_RST;
            cmd_reg   <= '0;
            len_reg   <= '0;
            info0_reg <= '0;
            info1_reg <= '0;
            rcrc_reg  <= '0;
            serr_reg  <= 1'b0;
            eerr_reg  <= 1'b0;
        end else if (step_en) begin
            if (res_valid || in_action) begin
                // Judged or idle: clear the burst.
                cnt_reg   <= '0;
                crc_reg   <= crc_init;
                cmd_reg   <= '0;
                len_reg   <= '0;
                info0_reg <= '0;
                info1_reg <= '0;
                rcrc_reg  <= '0;
                serr_reg  <= 1'b0;
                eerr_reg  <= 1'b0;
            end else begin
                cnt_reg   <= cnt_next;
                crc_reg   <= crc_next;
                cmd_reg   <= cmd_next;
                len_reg   <= len_next;
                info0_reg <= info0_next;
                info1_reg <= info1_next;
                rcrc_reg  <= rcrc_next;
                serr_reg  <= serr_next;
                eerr_reg  <= eerr_next;
            end
        end
    end

    assign burst_cnt = cnt_reg;

endmodule

`default_nettype wire

FILE: sv/cfrc_out_stage.sv
// Result register of the command frame receiver: holds one result word
// until the downstream side takes it. Uses cfrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfrc_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire cfrc_pkg::result_t               load_data,
    output logic                                 can_load,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[2:0], command_code[10:3], info_length[18:11], info_first[26:19],
    // info_second[34:27], frame_crc[50:35], zero[55:51]
    output logic [cfrc_pkg::TDATA_W-1:0]         m_tdata
);

    logic              valid_reg, valid_next;
    cfrc_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(cfrc_pkg::TDATA_W - cfrc_pkg::RESULT_W){1'b0}}, data_reg};

endmodule

`default_nettype wire

FILE: sv/command_frame_receiver_core.sv
// Command frame receiver: judges FF AA AA FF ... EE 55 55 EE command frames
// from a stream of received bytes. Uses cfrc_pkg, cfrc_frame_check,
// cfrc_out_stage and command_frame_receiver_core_assert.svh.
//
// Usage:
//   Input words carry a received byte in s_tdata, or with s_tuser high an
//   idle-line event that ends the burst. A frame is judged at the idle event,
//   or at the byte that fills BUFFER_DEPTH; one result word then goes out on
//   m_* with status, command, length, two info bytes and the computed CRC.
//   An idle event on an empty burst yields nothing.
//   cfg_data sets the CRC start value; it is always accepted and is picked
//   up at the first byte of the next burst.
// Timing:
//   An accepted word waits in the input register and is judged as it leaves;
//   its result is then loaded into the result register, which drives m_tvalid.
//   One word per cycle is taken as long as the result register is free or
//   being drained.
// Reset clears the burst, empties both registers and sets the CRC start
// value to FFFF. When m_tready stays low, the held result blocks only a word
// that would make another result; s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "command_frame_receiver_core_assert.svh"

module command_frame_receiver_core #(
    parameter int BUFFER_DEPTH = cfrc_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // rx_byte[7:0]
    input  wire logic [7:0]                    s_tdata,
    // action[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[2:0], command_code[10:3], info_length[18:11], info_first[26:19],
    // info_second[34:27], frame_crc[50:35], zero[55:51]
    output logic [cfrc_pkg::TDATA_W-1:0]       m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [15:0]                   cfg_data
);

    logic        in_valid_reg, in_valid_next;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] crc_init_reg;

    logic              res_valid;
    cfrc_pkg::result_t res_data;
    logic [cfrc_pkg::COUNT_W-1:0] burst_cnt;
    logic              can_load;
    logic              advance;
    logic              s_accept;

    assign advance   = in_valid_reg && (!res_valid || can_load);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            crc_init_reg <= cfrc_pkg::CRC_INIT_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid) begin
                crc_init_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    cfrc_frame_check #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .in_action (in_action_reg),
        .in_byte   (in_byte_reg),
        .crc_init  (crc_init_reg),
        .res_valid (res_valid),
        .res_data  (res_data),
        .burst_cnt (burst_cnt)
    );

    cfrc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_data (res_data),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `CFRC_ASSERT_ALWAYS(a_cnt_bound, 32'(burst_cnt) < BUFFER_DEPTH, "burst count reached depth")
    `CFRC_ASSERT_ALWAYS(a_status_range,
        !m_tvalid || m_tdata[2:0] <= cfrc_pkg::STATUS_BAD_END, "status out of range")
    `CFRC_ASSERT_ALWAYS(a_empty_idle,
        !(in_valid_reg && in_action_reg && burst_cnt == '0 && res_valid),
        "result from empty burst")
    `CFRC_ASSERT_NEXT(a_judge_clears, advance && res_valid, m_tvalid && burst_cnt == '0,
        "judged burst not cleared")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for command_frame_receiver_core: streams bursts of received bytes
// and idle events, predicts each frame verdict and compares every result word.
// Depends on cfrc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int FILL_LIMIT    = cfrc_pkg::BUFFER_DEPTH_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 500;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_IDLE = 1'b1;

    localparam logic [31:0] START_SEQ = 32'hFFAAAAFF;
    localparam logic [31:0] END_SEQ   = 32'hEE5555EE;

    localparam logic [7:0] CMD_NONE       = 8'h00;
    localparam logic [7:0] CMD_PAST_RANGE = 8'h07;
    localparam logic [7:0] CMD_ALL_ONES   = 8'hFF;

    typedef enum int {FLAW_NONE, FLAW_START, FLAW_CRC, FLAW_END, FLAW_TRAIL, FLAW_CUT}
        frame_flaw_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx;
    } rx_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [cfrc_pkg::TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    always #6 aclk = ~aclk;

    command_frame_receiver_core #(.BUFFER_DEPTH(FILL_LIMIT)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    rx_word_t           pending_words[$];
    cfrc_pkg::result_t  expected_results[$];
    logic [7:0]         frame_buf[$];

    int words_queued = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int mismatches = 0;
    int seeds_used = 1;
    int status_count [8];
    int cycle_count = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;

    // Frame checker copy: CRC seed register and the open burst.
    logic [15:0] crc_seed_cfg = cfrc_pkg::CRC_INIT_RST;
    int          burst_bytes = 0;
    logic [15:0] burst_crc = cfrc_pkg::CRC_INIT_RST;
    logic [7:0]  burst_cmd = 8'h00;
    int          burst_len = 0;
    logic [7:0]  burst_info0 = 8'h00;
    logic [7:0]  burst_info1 = 8'h00;
    logic [15:0] burst_rx_crc = 16'h0000;
    bit          start_bad = 1'b0;
    bit          end_bad = 1'b0;

    cfrc_pkg::result_t seen_result;
    cfrc_pkg::result_t want_result;

    function automatic logic [15:0] crc16_shift_in(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ d[k];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ cfrc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic int legal_length(input logic [7:0] cmd);
        if (cmd == cfrc_pkg::CMD_NO_INFO) return 0;
        if (cmd == cfrc_pkg::CMD_TWO_INFO) return 2;
        return 1;
    endfunction

    function automatic bit length_fits_command(input logic [7:0] cmd, input int len);
        if (cmd == cfrc_pkg::CMD_NO_INFO) return len == 0;
        if (cmd == cfrc_pkg::CMD_TWO_INFO) return len == 2;
        if (cmd >= cfrc_pkg::CMD_ONE_LO && cmd <= cfrc_pkg::CMD_ONE_HI) return len == 1;
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // Judge the open burst, queue its verdict, and start a fresh burst.
    task automatic close_burst();
        cfrc_pkg::result_t v;
        if (start_bad) begin
            v.status = cfrc_pkg::STATUS_BAD_START;
        end else if (burst_bytes < 6 || burst_bytes < 12 + burst_len) begin
            v.status = cfrc_pkg::STATUS_INCOMPLETE;
        end else if (burst_rx_crc != burst_crc) begin
            v.status = cfrc_pkg::STATUS_BAD_CRC;
        end else if (!length_fits_command(burst_cmd, burst_len)) begin
            v.status = cfrc_pkg::STATUS_BAD_CMD;
        end else if (end_bad) begin
            v.status = cfrc_pkg::STATUS_BAD_END;
        end else begin
            v.status = cfrc_pkg::STATUS_OK;
        end
        v.command_code = burst_cmd;
        v.info_length  = burst_len[7:0];
        v.info_first   = burst_info0;
        v.info_second  = burst_info1;
        v.frame_crc    = burst_crc;
        expected_results.push_back(v);
        burst_bytes  = 0;
        burst_crc    = crc_seed_cfg;
        burst_cmd    = 8'h00;
        burst_len    = 0;
        burst_info0  = 8'h00;
        burst_info1  = 8'h00;
        burst_rx_crc = 16'h0000;
        start_bad    = 1'b0;
        end_bad      = 1'b0;
    endtask

    task automatic take_rx_word(input logic action, input logic [7:0] b);
        int k;
        int t;
        if (action == ACT_IDLE) begin
            if (burst_bytes != 0) begin
                close_burst();
            end
        end else begin
            // Seed is latched at the first byte of each burst.
            if (burst_bytes == 0) begin
                burst_crc = crc_seed_cfg;
            end
            if (burst_bytes < 4) begin
                if (b != START_SEQ[8*(3-burst_bytes) +: 8]) begin
                    start_bad = 1'b1;
                end
                burst_crc = crc16_shift_in(burst_crc, b);
            end else if (burst_bytes == 4) begin
                burst_cmd = b;
                burst_crc = crc16_shift_in(burst_crc, b);
            end else if (burst_bytes == 5) begin
                burst_len = b;
                burst_crc = crc16_shift_in(burst_crc, b);
            end else begin
                k = burst_bytes - 6;
                if (k < burst_len) begin
                    burst_crc = crc16_shift_in(burst_crc, b);
                    if (k == 0) burst_info0 = b;
                    if (k == 1) burst_info1 = b;
                end else begin
                    t = k - burst_len;
                    if (t == 0) begin
                        burst_rx_crc[7:0] = b;
                    end else if (t == 1) begin
                        burst_rx_crc[15:8] = b;
                    end else if (t < 6) begin
                        if (b != END_SEQ[8*(5-t) +: 8]) begin
                            end_bad = 1'b1;
                        end
                    end
                end
            end
            burst_bytes++;
            if (burst_bytes >= FILL_LIMIT) begin
                close_burst();
            end
        end
    endtask

    // Sender: one word per handshake, random gaps after each word while tx_gaps_on.
    always @(posedge aclk) begin
        rx_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                take_rx_word(s_tuser, s_tdata);
                words_accepted++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                s_tdata  <= w.rx;
                s_tuser  <= w.action;
                s_tvalid <= 1'b1;
                gap_left = tx_gaps_on ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls while rx_stalls_on, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result = cfrc_pkg::result_t'(m_tdata[cfrc_pkg::RESULT_W-1:0]);
            status_count[seen_result.status]++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result at %0t: status %0d cmd %h len %h crc %h",
                             $realtime, seen_result.status, seen_result.command_code,
                             seen_result.info_length, seen_result.frame_crc);
                end
            end else begin
                want_result = expected_results.pop_front();
                results_checked++;
                if (seen_result.status !== want_result.status
                        || seen_result.command_code !== want_result.command_code
                        || seen_result.info_length !== want_result.info_length
                        || seen_result.info_first !== want_result.info_first
                        || seen_result.info_second !== want_result.info_second
                        || seen_result.frame_crc !== want_result.frame_crc
                        || m_tdata[cfrc_pkg::TDATA_W-1:cfrc_pkg::RESULT_W] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t (exp/got): status %0d/%0d cmd %h/%h len %h/%h",
                                 $realtime, want_result.status, seen_result.status,
                                 want_result.command_code, seen_result.command_code,
                                 want_result.info_length, seen_result.info_length);
                        $display("    info %h %h/%h %h crc %h/%h pad %h",
                                 want_result.info_first, want_result.info_second,
                                 seen_result.info_first, seen_result.info_second,
                                 want_result.frame_crc, seen_result.frame_crc,
                                 m_tdata[cfrc_pkg::TDATA_W-1:cfrc_pkg::RESULT_W]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_word(input logic action, input logic [7:0] b);
        rx_word_t w;
        w.action = action;
        w.rx = b;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic send_frame_buf(input int from, input int upto, input bit with_idle);
        logic [7:0] r;
        for (int i = from; i < upto; i++) begin
            push_word(ACT_BYTE, frame_buf[i]);
        end
        if (with_idle) begin
            r = $urandom_range(0, 255);
            push_word(ACT_IDLE, r);
        end
    endtask

    task automatic build_frame(input logic [7:0] cmd, input int len, input frame_flaw_t flaw);
        logic [15:0] acc;
        logic [7:0]  r;
        int          pos;
        int          keep;
        frame_buf.delete();
        for (int i = 0; i < 4; i++) frame_buf.push_back(START_SEQ[8*(3-i) +: 8]);
        frame_buf.push_back(cmd);
        frame_buf.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 255);
            frame_buf.push_back(r);
        end
        acc = crc_seed_cfg;
        foreach (frame_buf[i]) acc = crc16_shift_in(acc, frame_buf[i]);
        if (flaw == FLAW_CRC) begin
            acc = acc ^ (16'h0001 << $urandom_range(0, 15));
        end
        frame_buf.push_back(acc[7:0]);
        frame_buf.push_back(acc[15:8]);
        for (int i = 0; i < 4; i++) frame_buf.push_back(END_SEQ[8*(3-i) +: 8]);
        r = $urandom_range(1, 255);
        case (flaw)
            FLAW_START: begin
                pos = $urandom_range(0, 3);
                frame_buf[pos] = frame_buf[pos] ^ r;
            end
            FLAW_END: begin
                pos = frame_buf.size() - 1 - $urandom_range(0, 3);
                frame_buf[pos] = frame_buf[pos] ^ r;
            end
            FLAW_TRAIL: begin
                repeat ($urandom_range(1, 8)) begin
                    r = $urandom_range(0, 255);
                    frame_buf.push_back(r);
                end
            end
            FLAW_CUT: begin
                keep = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            end
            default: ;
        endcase
    endtask

    task automatic send_frame(input logic [7:0] cmd, input int len, input frame_flaw_t flaw);
        build_frame(cmd, len, flaw);
        send_frame_buf(0, frame_buf.size(), 1'b1);
    endtask

    task automatic random_burst();
        int          pick;
        logic [7:0]  cmd;
        logic [7:0]  r;
        cmd = $urandom_range(cfrc_pkg::CMD_NO_INFO, cfrc_pkg::CMD_ONE_HI);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_frame(cmd, legal_length(cmd), FLAW_NONE);
        end else if (pick < 65) begin
            send_frame(cmd, legal_length(cmd), FLAW_CRC);
        end else if (pick < 71) begin
            send_frame(cmd, legal_length(cmd), FLAW_END);
        end else if (pick < 77) begin
            send_frame(cmd, legal_length(cmd), FLAW_START);
        end else if (pick < 83) begin
            send_frame(cmd, legal_length(cmd), FLAW_CUT);
        end else if (pick < 88) begin
            send_frame(cmd, legal_length(cmd), FLAW_TRAIL);
        end else if (pick < 94) begin
            cmd = $urandom_range(0, 255);
            send_frame(cmd, $urandom_range(0, FILL_LIMIT - 12), FLAW_NONE);
        end else if (pick < 97) begin
            cmd = $urandom_range(0, 255);
            send_frame(cmd, $urandom_range(FILL_LIMIT - 11, 255), FLAW_CUT);
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(1, 20)) begin
                r = $urandom_range(0, 255);
                frame_buf.push_back(r);
            end
            send_frame_buf(0, frame_buf.size(), 1'b1);
        end
        // Idle on an empty burst now and then.
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 255);
            push_word(ACT_IDLE, r);
        end
    endtask

    // Hold until every queued word is taken and every verdict has come back.
    task automatic wait_drained();
        @(posedge aclk);
        while (words_accepted != words_queued || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_crc_seed(input logic [15:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        crc_seed_cfg = v;
        seeds_used++;
    endtask

    task automatic random_phase(input logic [15:0] seed, input bit gaps, input bit stalls,
                                input bit long_hold);
        int stop_at;
        wait_drained();
        write_crc_seed(seed);
        tx_gaps_on = gaps;
        rx_stalls_on = stalls;
        if (long_hold) hold_requests++;
        stop_at = words_queued + RANDOM_WORDS / 5;
        while (words_queued < stop_at) random_burst();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset seed.
        push_word(ACT_IDLE, 8'hFF);
        send_frame(cfrc_pkg::CMD_NO_INFO, 0, FLAW_NONE);
        send_frame(cfrc_pkg::CMD_TWO_INFO, 2, FLAW_NONE);
        send_frame(cfrc_pkg::CMD_ONE_LO, 1, FLAW_NONE);
        send_frame(cfrc_pkg::CMD_ONE_HI, 1, FLAW_NONE);
        send_frame(CMD_NONE, 0, FLAW_NONE);
        send_frame(CMD_PAST_RANGE, 1, FLAW_NONE);
        send_frame(cfrc_pkg::CMD_NO_INFO, 2, FLAW_NONE);
        send_frame(cfrc_pkg::CMD_TWO_INFO, 2, FLAW_CRC);
        send_frame(cfrc_pkg::CMD_ONE_LO, 1, FLAW_END);
        send_frame(cfrc_pkg::CMD_ONE_HI, 1, FLAW_START);
        send_frame(cfrc_pkg::CMD_TWO_INFO, 2, FLAW_TRAIL);
        // Short bursts: inside the start mark, before the length, before the CRC.
        build_frame(cfrc_pkg::CMD_TWO_INFO, 2, FLAW_NONE);
        send_frame_buf(0, 3, 1'b1);
        send_frame_buf(0, 5, 1'b1);
        send_frame_buf(0, 6, 1'b1);
        // Bad start outranks the short burst.
        push_word(ACT_BYTE, 8'h00);
        push_word(ACT_BYTE, 8'hFF);
        push_word(ACT_IDLE, 8'h00);
        // Bad CRC together with a bad end mark.
        build_frame(cfrc_pkg::CMD_NO_INFO, 0, FLAW_CRC);
        frame_buf[frame_buf.size() - 1] = 8'h00;
        send_frame_buf(0, frame_buf.size(), 1'b1);
        send_frame(CMD_ALL_ONES, 0, FLAW_END);

        wait_drained();
        write_crc_seed(16'h0000);
        // Frame that fills the buffer exactly; the idle after it finds nothing.
        send_frame(cfrc_pkg::CMD_TWO_INFO, FILL_LIMIT - 12, FLAW_NONE);
        send_frame(CMD_ALL_ONES, 255, FLAW_NONE);
        send_frame(cfrc_pkg::CMD_TWO_INFO, 2, FLAW_NONE);
        // Leave a burst open across a seed change.
        build_frame(cfrc_pkg::CMD_TWO_INFO, 2, FLAW_NONE);
        send_frame_buf(0, 9, 1'b0);
        wait_drained();
        write_crc_seed(16'hFFFF);
        send_frame_buf(9, frame_buf.size(), 1'b1);
        send_frame(cfrc_pkg::CMD_ONE_LO, 1, FLAW_NONE);

        random_phase($urandom_range(1, 16'hFFFE), 1'b1, 1'b1, 1'b0);
        random_phase(16'h0000, 1'b0, 1'b0, 1'b0);
        random_phase($urandom_range(0, 16'hFFFF), 1'b0, 1'b1, 1'b1);
        random_phase(16'hFFFF, 1'b1, 1'b1, 1'b0);
        random_phase(16'h1D0F, 1'b1, 1'b0, 1'b0);

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("%0d verdicts checked from %0d words across %0d CRC seeds", results_checked,
                 words_accepted, seeds_used);
        $display("verdict mix: ok %0d, bad start %0d, short %0d, bad crc %0d,",
                 status_count[cfrc_pkg::STATUS_OK], status_count[cfrc_pkg::STATUS_BAD_START],
                 status_count[cfrc_pkg::STATUS_INCOMPLETE],
                 status_count[cfrc_pkg::STATUS_BAD_CRC]);
        $display("    bad cmd %0d, bad end %0d",
                 status_count[cfrc_pkg::STATUS_BAD_CMD], status_count[cfrc_pkg::STATUS_BAD_END]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: command_frame_receiver_core.f
+incdir+sv
sv/cfrc_pkg.sv
sv/cfrc_frame_check.sv
sv/cfrc_out_stage.sv
sv/command_frame_receiver_core.sv
sim/tb_top.sv
